/* hdl/assert_macros.svh */
// Assertion macros shared by the hit interval combiner RTL.
// No dependencies; simulation builds get the checks, synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check that is held off while reset is asserted
`define CHC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that must also hold through reset
`define CHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CHC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/chc_pkg.sv */
// Types, codes and helper function for the hit interval combiner.
// No dependencies; used by chc_merge and csg_hit_interval_combiner.
`default_nettype none

package chc_pkg;

  localparam int DIST_W = 32;
  localparam int IDX_W  = 4;

  // boolean operation codes
  typedef enum logic [1:0] {
    OP_UNION            = 2'd0,
    OP_INTERSECT        = 2'd1,
    OP_LEFT_MINUS_RIGHT = 2'd2
  } chc_op_t;

  // merge sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_FINISH
  } chc_state_t;

  // winning hit as handed from the merge unit to the output register
  typedef struct packed {
    logic              found;
    logic              side;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } chc_win_t;

  // inside state of the combined solid; unused code is never inside
  function automatic logic combined_inside(chc_op_t op, logic in_l, logic in_r);
    case (op)
      OP_UNION:            combined_inside = in_l | in_r;
      OP_INTERSECT:        combined_inside = in_l & in_r;
      OP_LEFT_MINUS_RIGHT: combined_inside = in_l & ~in_r;
      default:             combined_inside = 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* hdl/chc_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module chc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/chc_merge.sv */
// Merge sequencer: walks both hit lists with one shared distance comparator.
// Depends on chc_pkg and assert_macros.svh; reads the two hit RAMs.
`default_nettype none
`include "assert_macros.svh"

module chc_merge #(
  parameter int MAX_HITS = 16,
  localparam int CW = $clog2(MAX_HITS + 1),
  localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  chc_pkg::chc_op_t              op,
  input  logic [CW-1:0]                 left_count,
  input  logic [CW-1:0]                 right_count,
  input  logic                          left_start,
  input  logic                          right_start,
  input  logic [chc_pkg::DIST_W-1:0]    l_rdata,
  input  logic [chc_pkg::DIST_W-1:0]    r_rdata,
  output logic [IW-1:0]                 l_raddr,
  output logic [IW-1:0]                 r_raddr,
  input  logic                          slot_free,
  output logic                          busy,
  output logic                          done,
  output chc_pkg::chc_win_t             win
);

  import chc_pkg::*;

  chc_state_t    state_r, state_nxt;
  logic [CW-1:0] li_r, li_nxt;
  logic [CW-1:0] ri_r, ri_nxt;
  logic          in_l_r, in_l_nxt;
  logic          in_r_r, in_r_nxt;
  chc_win_t      win_r, win_nxt;

  logic          l_more, r_more;
  logic          take_left;
  logic          was_in, now_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      li_r    <= '0;
      ri_r    <= '0;
      in_l_r  <= 1'b0;
      in_r_r  <= 1'b0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      li_r    <= li_nxt;
      ri_r    <= ri_nxt;
      in_l_r  <= in_l_nxt;
      in_r_r  <= in_r_nxt;
      win_r   <= win_nxt;
    end
  end

  // RAM addresses follow the list heads; read data is registered and valid in the following cycle
  assign l_raddr = li_r[IW-1:0];
  assign r_raddr = ri_r[IW-1:0];

  // shared comparator: left wins ties
  assign l_more    = (li_r < left_count);
  assign r_more    = (ri_r < right_count);
  assign take_left = l_more && (!r_more || (l_rdata <= r_rdata));

  always_comb begin
    state_nxt = state_r;
    li_nxt    = li_r;
    ri_nxt    = ri_r;
    in_l_nxt  = in_l_r;
    in_r_nxt  = in_r_r;
    win_nxt   = win_r;
    done      = 1'b0;
    was_in    = 1'b0;
    now_in    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          li_nxt   = '0;
          ri_nxt   = '0;
          in_l_nxt = left_start;
          in_r_nxt = right_start;
          win_nxt  = '0;
          if ((left_count != '0) || (right_count != '0)) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        was_in = combined_inside(op, in_l_r, in_r_r);
        if (take_left) begin
          in_l_nxt = ~in_l_r;
          li_nxt   = li_r + CW'(1);
        end else begin
          in_r_nxt = ~in_r_r;
          ri_nxt   = ri_r + CW'(1);
        end
        now_in = combined_inside(op, in_l_nxt, in_r_nxt);
        if (!was_in && now_in) begin
          win_nxt.found    = 1'b1;
          win_nxt.side     = ~take_left;
          win_nxt.index    = take_left ? IDX_W'(li_r) : IDX_W'(ri_r);
          win_nxt.distance = take_left ? l_rdata : r_rdata;
          state_nxt        = ST_FINISH;
        end else if ((li_nxt < left_count) || (ri_nxt < right_count)) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign win  = win_r;

  `CHC_ASSERT_ALWAYS(a_no_start_busy, clk, !(start && busy), "evaluate taken while merging")
  `CHC_ASSERT(a_li_bound, clk, rst_n, (state_r != ST_IDLE) |-> (li_r <= left_count), "left head past list end")
  `CHC_ASSERT(a_ri_bound, clk, rst_n, (state_r != ST_IDLE) |-> (ri_r <= right_count), "right head past list end")
  `CHC_ASSERT(a_cmp_work, clk, rst_n, (state_r == ST_CMP) |-> (l_more || r_more), "compare with both lists empty")

endmodule

`default_nettype wire

/* hdl/csg_hit_interval_combiner.sv */
// Top level of the hit interval combiner: hit storage, counts, output register.
// Depends on chc_pkg, chc_ram and chc_merge.
//
// Usage. One ray at a time. Input requests (in_valid/in_stall) carry either a
// child hit (in_func = 0: side, distance, entering flag) or an evaluate
// request (in_func = 1). Hits are appended to the left or right list, one per
// cycle while in_stall is low, up to MAX_HITS per side; extra hits are
// dropped and flagged. An evaluate request raises in_stall while the merge
// sequencer walks both lists with a single shared comparator, each hit visited
// taking a RAM read and then a compare and toggle, stopping at the first entry
// into the combined solid. Input reopens in the same cycle as out_valid rises,
// so no new hit or evaluate is taken while an evaluate is in progress.
// Results (out_valid/out_stall) sit in an output register; add requests are
// still taken while a result waits, and a following evaluate completes its
// walk and then holds in_stall until the waiting result is taken.
// The lists and flags are cleared as the result is written.
// Reset (rst_n low, synchronous) empties both lists, clears the overflow flag,
// drops any pending result and sets the operation to union. cfg_we writes the
// operation (0 union, 1 intersection, 2 left minus right); the user must write
// it only while idle, which the block itself does not enforce.
`default_nettype none

module csg_hit_interval_combiner #(
  parameter int MAX_HITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_wdata,
  // input requests
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic                       in_from_right,
  input  logic [chc_pkg::DIST_W-1:0] in_hit_distance,
  input  logic                       in_entering,
  // result requests
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_found,
  output logic                       out_winner_side,
  output logic [chc_pkg::IDX_W-1:0]  out_winner_index,
  output logic [chc_pkg::DIST_W-1:0] out_winner_distance,
  output logic                       out_overflowed
);

  import chc_pkg::*;

  localparam int CW = $clog2(MAX_HITS + 1);
  localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;

  // configuration and list state
  chc_op_t       op_r, op_nxt;
  logic [CW-1:0] lcnt_r, lcnt_nxt;
  logic [CW-1:0] rcnt_r, rcnt_nxt;
  logic          lstart_r, lstart_nxt;
  logic          rstart_r, rstart_nxt;
  logic          ovf_r, ovf_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  chc_win_t      out_win_r;
  logic          out_ovf_r;

  // handshake decode
  logic          add_acc, eval_acc;
  logic          l_room, r_room;
  logic          l_we, r_we;
  logic          slot_free;

  // merge unit links
  logic [IW-1:0]     l_raddr, r_raddr;
  logic [DIST_W-1:0] l_rdata, r_rdata;
  logic              m_busy, m_done;
  chc_win_t          m_win;

  assign add_acc   = in_valid && !in_stall && !in_func;
  assign eval_acc  = in_valid && !in_stall && in_func;
  assign l_room    = (lcnt_r < CW'(MAX_HITS));
  assign r_room    = (rcnt_r < CW'(MAX_HITS));
  assign l_we      = add_acc && !in_from_right && l_room;
  assign r_we      = add_acc && in_from_right && r_room;
  assign slot_free = !out_valid_r || !out_stall;

  // busy only while an evaluate walks the lists or waits for the output slot
  assign in_stall  = m_busy;

  chc_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_HITS)
  ) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (lcnt_r[IW-1:0]),
    .wdata (in_hit_distance),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  chc_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_HITS)
  ) u_right_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (rcnt_r[IW-1:0]),
    .wdata (in_hit_distance),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  chc_merge #(
    .MAX_HITS (MAX_HITS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (eval_acc),
    .op          (op_r),
    .left_count  (lcnt_r),
    .right_count (rcnt_r),
    .left_start  (lstart_r),
    .right_start (rstart_r),
    .l_rdata     (l_rdata),
    .r_rdata     (r_rdata),
    .l_raddr     (l_raddr),
    .r_raddr     (r_raddr),
    .slot_free   (slot_free),
    .busy        (m_busy),
    .done        (m_done),
    .win         (m_win)
  );

  // list bookkeeping; a finished evaluate clears the lists and flags
  always_comb begin
    op_nxt     = cfg_we ? chc_op_t'(cfg_wdata) : op_r;
    lcnt_nxt   = lcnt_r;
    rcnt_nxt   = rcnt_r;
    lstart_nxt = lstart_r;
    rstart_nxt = rstart_r;
    ovf_nxt    = ovf_r;
    if (m_done) begin
      lcnt_nxt   = '0;
      rcnt_nxt   = '0;
      lstart_nxt = 1'b0;
      rstart_nxt = 1'b0;
      ovf_nxt    = 1'b0;
    end else if (add_acc) begin
      if (!in_from_right) begin
        if (l_room) begin
          lcnt_nxt = lcnt_r + CW'(1);
          // an exit as first hit means the ray starts inside
          if (lcnt_r == '0) begin
            lstart_nxt = ~in_entering;
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end else begin
        if (r_room) begin
          rcnt_nxt = rcnt_r + CW'(1);
          if (rcnt_r == '0) begin
            rstart_nxt = ~in_entering;
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  assign out_valid_nxt = m_done || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_UNION;
      lcnt_r      <= '0;
      rcnt_r      <= '0;
      lstart_r    <= 1'b0;
      rstart_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      op_r        <= op_nxt;
      lcnt_r      <= lcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      lstart_r    <= lstart_nxt;
      rstart_r    <= rstart_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded only when the slot is free
  always_ff @(posedge clk) begin
    if (m_done) begin
      out_win_r <= m_win;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_win_r.found;
  assign out_winner_side     = out_win_r.side;
  assign out_winner_index    = out_win_r.index;
  assign out_winner_distance = out_win_r.distance;
  assign out_overflowed      = out_ovf_r;

endmodule

`default_nettype wire
